FILE: design/fpa_pkg.sv
// Shared types, command codes and saturation helpers for the Q24.8 fixed-point ALU.
// Used by every module of the block; depends on nothing.
`default_nettype none
package fpa_pkg;

    localparam int FpaFracBits = 8;

    typedef enum logic [3:0] {
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT, CMD_LT, CMD_GE, CMD_LE,
        CMD_EQ, CMD_NE, CMD_MIN, CMD_MAX, CMD_INC, CMD_DEC, CMD_TO_INT, CMD_FROM_INT
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;

    // Sideband carried down the pipeline with every transaction.
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] res;    // finished result of the simple commands
        logic        cmp;
        logic [1:0]  st;
        logic [63:0] prod;   // magnitude product for multiply
        logic        neg;    // sign of product or quotient
        logic        divz;
    } side_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } clamp_t;

    function automatic clamp_t clamp_wide(input logic signed [63:0] v);
        clamp_t c;
        c.sat = 1'b0;
        c.val = v[31:0];
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            c.sat = 1'b1;
            c.val = 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            c.sat = 1'b1;
            c.val = 32'h8000_0000;
        end
        return c;
    endfunction

    function automatic clamp_t clamp_mag(input logic neg, input logic [63:0] mag);
        clamp_t c;
        c.sat = 1'b0;
        c.val = 32'd0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                c.sat = 1'b1;
                c.val = 32'h8000_0000;
            end else begin
                c.val = (~mag[31:0]) + 32'd1;
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                c.sat = 1'b1;
                c.val = 32'h7FFF_FFFF;
            end else begin
                c.val = mag[31:0];
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: design/fpa_div_step.sv
// One registered step of the restoring long divider: one quotient bit per stage.
// Depends on fpa_pkg for the sideband type.
`default_nettype none
module fpa_div_step
    import fpa_pkg::*;
#(
    parameter int NW  = 40,
    parameter int IDX = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire side_t         in_side,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [31:0]   in_den,
    input  wire logic [31:0]   in_rem,
    input  wire logic [NW-1:0] in_quo,
    output logic               out_valid,
    output side_t              out_side,
    output logic [NW-1:0]      out_num,
    output logic [31:0]        out_den,
    output logic [31:0]        out_rem,
    output logic [NW-1:0]      out_quo
);

    localparam int Bit = NW - 1 - IDX;

    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          fits;
    logic [31:0]   rem_next;
    logic [NW-1:0] quo_next;
    logic          valid_reg;
    side_t         side_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [31:0]   den_reg;
    logic [31:0]   rem_reg;

    always_comb begin
        trial    = {in_rem, in_num[Bit]};
        fits     = trial >= {1'b0, in_den};
        diff     = trial - {1'b0, in_den};
        rem_next = fits ? diff[31:0] : trial[31:0];
        quo_next = in_quo;
        quo_next[Bit] = fits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            num_reg  <= in_num;
            den_reg  <= in_den;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule
`default_nettype wire

FILE: design/fpa_round.sv
// Rounding stage: round the product and the quotient to nearest, halves away from zero.
// Depends on fpa_pkg for the sideband type.
`default_nettype none
module fpa_round
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FpaFracBits,
    parameter int NW            = 32 + FpaFracBits
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire side_t         in_side,
    input  wire logic [31:0]   in_den,
    input  wire logic [31:0]   in_rem,
    input  wire logic [NW-1:0] in_quo,
    output logic               out_valid,
    output side_t              out_side,
    output logic [63:0]        out_mul_mag,
    output logic [63:0]        out_div_mag
);

    localparam logic [63:0] Half = 64'd1 << (FRACTION_BITS - 1);

    logic [63:0] mul_sum;
    logic        up;
    logic        valid_reg;
    side_t       side_reg;
    logic [63:0] mul_reg;
    logic [63:0] div_reg;

    always_comb begin
        mul_sum = in_side.prod + Half;
        // remainder at least half the divisor rounds the quotient up
        up      = {in_rem, 1'b0} >= {1'b0, in_den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            mul_reg  <= mul_sum >> FRACTION_BITS;
            div_reg  <= 64'(in_quo) + 64'(up);
        end
    end

    assign out_valid   = valid_reg;
    assign out_side    = side_reg;
    assign out_mul_mag = mul_reg;
    assign out_div_mag = div_reg;

endmodule
`default_nettype wire

FILE: design/fixed_point_alu_q24_8_core.sv
// Top level of the signed Q24.8 fixed-point ALU pipeline.
// Depends on fpa_pkg, fpa_div_step and fpa_round.
//
// Usage:
//   Input channel s_*: one transaction carries a command and two raw operands.
//   Result channel m_*: one transaction per input, in order, with the raw
//   result, the comparison outcome and a status code (ok, saturated, divide
//   by zero).
//   From input accept to m_valid a transaction passes one input register, one
//   operand stage, one stage per quotient bit of the restoring divider
//   (32 + FRACTION_BITS of them), one rounding stage and the output register.
//   Every command takes the same path so results leave in order.
//   Throughput is one transaction per cycle while m_ready does not stall the
//   pipeline; the divider is fully unrolled, one quotient bit per stage.
//   When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes and s_ready drops; no transaction is dropped or repeated.
//   A bubble in the output register lets the pipeline advance regardless.
//   Reset clears all valid bits; payload registers hold stale data.
`default_nettype none
module fixed_point_alu_q24_8_core
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FpaFracBits
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_command,
    input  wire logic signed [31:0] s_operand_a,
    input  wire logic signed [31:0] s_operand_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_result_value,
    output logic             m_compare_true,
    output logic [1:0]       m_status
);

    localparam int NW = 32 + FRACTION_BITS;
    localparam logic signed [63:0] One = 64'sd1 <<< FRACTION_BITS;

    logic m_valid_reg;

    // advance the pipeline whenever the output slot is free or being taken
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // input register
    logic               in_valid_reg;
    logic [3:0]         in_cmd_reg;
    logic signed [31:0] in_a_reg;
    logic signed [31:0] in_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_cmd_reg <= s_command;
            in_a_reg   <= s_operand_a;
            in_b_reg   <= s_operand_b;
        end
    end

    // operand stage: finish the simple commands, form the magnitude product
    // and set up the divider
    side_t       side_next;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    clamp_t      cw;
    logic signed [63:0] wa;
    logic signed [63:0] wb;

    always_comb begin
        wa    = 64'(in_a_reg);
        wb    = 64'(in_b_reg);
        mag_a = in_a_reg[31] ? (~in_a_reg) + 32'd1 : in_a_reg;
        mag_b = in_b_reg[31] ? (~in_b_reg) + 32'd1 : in_b_reg;
        side_next.cmd  = cmd_t'(in_cmd_reg);
        side_next.res  = 32'd0;
        side_next.cmp  = 1'b0;
        side_next.st   = ST_OK;
        side_next.prod = 64'(mag_a) * 64'(mag_b);
        side_next.neg  = in_a_reg[31] ^ in_b_reg[31];
        side_next.divz = (in_b_reg == 32'sd0);
        cw.val = 32'd0;
        cw.sat = 1'b0;
        case (cmd_t'(in_cmd_reg))
            CMD_ADD:      cw = clamp_wide(wa + wb);
            CMD_SUB:      cw = clamp_wide(wa - wb);
            CMD_INC:      cw = clamp_wide(wa + One);
            CMD_DEC:      cw = clamp_wide(wa - One);
            CMD_FROM_INT: cw = clamp_wide(wa <<< FRACTION_BITS);
            default:      cw = cw;
        endcase
        case (cmd_t'(in_cmd_reg))
            CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC, CMD_FROM_INT: begin
                side_next.res = cw.val;
                side_next.st  = cw.sat ? ST_SAT : ST_OK;
            end
            CMD_GT:     side_next.cmp = in_a_reg >  in_b_reg;
            CMD_LT:     side_next.cmp = in_a_reg <  in_b_reg;
            CMD_GE:     side_next.cmp = in_a_reg >= in_b_reg;
            CMD_LE:     side_next.cmp = in_a_reg <= in_b_reg;
            CMD_EQ:     side_next.cmp = in_a_reg == in_b_reg;
            CMD_NE:     side_next.cmp = in_a_reg != in_b_reg;
            CMD_MIN:    side_next.res = (in_a_reg < in_b_reg) ? in_a_reg : in_b_reg;
            CMD_MAX:    side_next.res = (in_a_reg > in_b_reg) ? in_a_reg : in_b_reg;
            CMD_TO_INT: side_next.res = in_a_reg >>> FRACTION_BITS;
            default:    side_next.res = 32'd0;
        endcase
    end

    // divider chain, index 0 is the operand stage output
    logic          vp   [NW+1];
    side_t         sp   [NW+1];
    logic [NW-1:0] nump [NW+1];
    logic [31:0]   denp [NW+1];
    logic [31:0]   remp [NW+1];
    logic [NW-1:0] quop [NW+1];

    logic          op_valid_reg;
    side_t         op_side_reg;
    logic [NW-1:0] op_num_reg;
    logic [31:0]   op_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
        end else if (en) begin
            op_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_side_reg <= side_next;
            op_num_reg  <= {mag_a, FRACTION_BITS'(0)};
            op_den_reg  <= mag_b;
        end
    end

    assign vp[0]   = op_valid_reg;
    assign sp[0]   = op_side_reg;
    assign nump[0] = op_num_reg;
    assign denp[0] = op_den_reg;
    assign remp[0] = 32'd0;
    assign quop[0] = '0;

    for (genvar i = 0; i < NW; i++) begin : g_div
        fpa_div_step #(
            .NW (NW),
            .IDX(i)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (vp[i]),
            .in_side  (sp[i]),
            .in_num   (nump[i]),
            .in_den   (denp[i]),
            .in_rem   (remp[i]),
            .in_quo   (quop[i]),
            .out_valid(vp[i+1]),
            .out_side (sp[i+1]),
            .out_num  (nump[i+1]),
            .out_den  (denp[i+1]),
            .out_rem  (remp[i+1]),
            .out_quo  (quop[i+1])
        );
    end

    // rounding stage
    logic        rd_valid;
    side_t       rd_side;
    logic [63:0] rd_mul_mag;
    logic [63:0] rd_div_mag;

    fpa_round #(
        .FRACTION_BITS(FRACTION_BITS),
        .NW           (NW)
    ) u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (vp[NW]),
        .in_side    (sp[NW]),
        .in_den     (denp[NW]),
        .in_rem     (remp[NW]),
        .in_quo     (quop[NW]),
        .out_valid  (rd_valid),
        .out_side   (rd_side),
        .out_mul_mag(rd_mul_mag),
        .out_div_mag(rd_div_mag)
    );

    // saturate and select into the output register
    clamp_t      cm;
    logic [31:0] res_next;
    logic [1:0]  st_next;

    always_comb begin
        cm.val   = 32'd0;
        cm.sat   = 1'b0;
        res_next = rd_side.res;
        st_next  = rd_side.st;
        case (rd_side.cmd)
            CMD_MUL: begin
                cm       = clamp_mag(rd_side.neg && (rd_mul_mag != 64'd0), rd_mul_mag);
                res_next = cm.val;
                st_next  = cm.sat ? ST_SAT : ST_OK;
            end
            CMD_DIV: begin
                cm = clamp_mag(rd_side.neg && (rd_div_mag != 64'd0), rd_div_mag);
                if (rd_side.divz) begin
                    res_next = 32'd0;
                    st_next  = ST_DIVZ;
                end else begin
                    res_next = cm.val;
                    st_next  = cm.sat ? ST_SAT : ST_OK;
                end
            end
            default: begin
                res_next = rd_side.res;
                st_next  = rd_side.st;
            end
        endcase
    end

    logic [31:0] m_res_reg;
    logic        m_cmp_reg;
    logic [1:0]  m_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_reg <= res_next;
            m_cmp_reg <= rd_side.cmp;
            m_st_reg  <= st_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_res_reg;
    assign m_compare_true = m_cmp_reg;
    assign m_status       = m_st_reg;

endmodule
`default_nettype wire

FILE: tb/sv/fixed_point_alu_q24_8_core_test.sv
// Self-checking testbench for the Q24.8 fixed-point ALU core: random and directed commands,
// predicted results compared in order. Depends on fpa_pkg and fixed_point_alu_q24_8_core.
`default_nettype none
module fixed_point_alu_q24_8_core_test;
    import fpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FpaFracBits;
    localparam int LATENCY = FRAC + 36;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
    } alu_op_t;

    typedef struct {
        logic [31:0] value;
        logic        cmp;
        logic [1:0]  st;
    } alu_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_command = '0;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_result_value;
    logic        m_compare_true;
    logic [1:0]  m_status;

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       error_count = 0;
    int       cycle_count = 0;
    bit       stimulus_done = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;

    fixed_point_alu_q24_8_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_compare_true(m_compare_true), .m_status(m_status)
    );

    always #10 aclk = ~aclk;

    // Saturate a wide signed value to 32 bits.
    function automatic void saturate_wide(input logic signed [65:0] v,
                                          output logic [31:0] r, inout logic [1:0] st);
        if (v > 66'sd2147483647) begin
            r = 32'h7FFF_FFFF;
            st = ST_SAT;
        end else if (v < -66'sd2147483648) begin
            r = 32'h8000_0000;
            st = ST_SAT;
        end else begin
            r = v[31:0];
        end
    endfunction

    // Compute the expected result of one ALU operation.
    function automatic alu_res_t compute_alu(input alu_op_t op);
        alu_res_t r;
        logic signed [31:0] a, b;
        logic signed [65:0] wide;
        logic [63:0] ma, mb, mag, num, quo, rem;
        logic neg;
        a = op.a;
        b = op.b;
        r.value = '0;
        r.cmp = 1'b0;
        r.st = ST_OK;
        ma = a < 0 ? 64'(-66'(a)) : 64'(a);
        mb = b < 0 ? 64'(-66'(b)) : 64'(b);
        neg = (a < 0) != (b < 0);
        mag = '0;
        case (cmd_t'(op.cmd))
            CMD_ADD: saturate_wide(66'(a) + 66'(b), r.value, r.st);
            CMD_SUB: saturate_wide(66'(a) - 66'(b), r.value, r.st);
            CMD_MUL: begin
                mag = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
            end
            CMD_DIV: begin
                if (b == 0) begin
                    r.st = ST_DIVZ;
                end else begin
                    num = ma << FRAC;
                    quo = num / mb;
                    rem = num - quo * mb;
                    // round half away from zero
                    if (rem >= mb - rem) quo = quo + 1;
                    mag = quo;
                end
            end
            CMD_GT: r.cmp = a > b;
            CMD_LT: r.cmp = a < b;
            CMD_GE: r.cmp = a >= b;
            CMD_LE: r.cmp = a <= b;
            CMD_EQ: r.cmp = a == b;
            CMD_NE: r.cmp = a != b;
            CMD_MIN: r.value = (a < b) ? a : b;
            CMD_MAX: r.value = (a > b) ? a : b;
            CMD_INC: saturate_wide(66'(a) + (66'sd1 <<< FRAC), r.value, r.st);
            CMD_DEC: saturate_wide(66'(a) - (66'sd1 <<< FRAC), r.value, r.st);
            CMD_TO_INT: r.value = a >>> FRAC;
            default: saturate_wide(66'(a) <<< FRAC, r.value, r.st);
        endcase
        if (op.cmd == CMD_MUL || (op.cmd == CMD_DIV && b != 0)) begin
            if (neg && mag != 0) begin
                if (mag > 64'h8000_0000) begin
                    r.value = 32'h8000_0000;
                    r.st = ST_SAT;
                end else begin
                    r.value = -mag[31:0];
                end
            end else if (mag > 64'h7FFF_FFFF) begin
                r.value = 32'h7FFF_FFFF;
                r.st = ST_SAT;
            end else begin
                r.value = mag[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? $urandom_range(0, 512)
                                           : -$urandom_range(0, 512);
            3, 4: return $urandom_range(0, 1) ? $urandom_range(0, 32'h10000)
                                              : -$urandom_range(0, 32'h10000);
            5: return 32'($signed($urandom())) >>> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Fill the queue: directed corner cases first, then random operations.
    initial begin
        alu_op_t op;
        logic [31:0] corners[6];
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF80};
        for (int c = 0; c < 16; c++) begin
            op.cmd = c[3:0];
            op.a = corners[c % 6];
            op.b = corners[(c + 1) % 6];
            pending_ops.push_back(op);
        end
        // divide by zero, rounding halves, saturating multiply
        pending_ops.push_back('{CMD_DIV, 32'h100, 32'h0});
        pending_ops.push_back('{CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF});
        pending_ops.push_back('{CMD_MUL, 32'h1, 32'h80});
        pending_ops.push_back('{CMD_MUL, 32'hFFFF_FFFF, 32'h80});
        pending_ops.push_back('{CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000});
        pending_ops.push_back('{CMD_DIV, 32'h1, 32'h200});
        pending_ops.push_back('{CMD_TO_INT, 32'hFFFF_FF01, 32'h0});
        pending_ops.push_back('{CMD_EQ, 32'h8000_0000, 32'h8000_0000});
        for (int i = 0; i < 750; i++) begin
            op.cmd = 4'($urandom_range(0, 15));
            op.a = pick_operand();
            op.b = pick_operand();
            if (op.cmd == CMD_DIV && $urandom_range(0, 19) == 0) op.b = '0;
            pending_ops.push_back(op);
        end
        stimulus_done = 1'b1;
    end

    // Hold reset low at the start of the run, then release it for good.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: advance on acceptance, otherwise hold the transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(compute_alu('{s_command, s_operand_a,
                                                         s_operand_b}));
                send_gap = pick_gap();
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || pending_ops.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    alu_op_t nxt;
                    nxt = pending_ops.pop_front();
                    s_valid <= 1'b1;
                    s_command <= nxt.cmd;
                    s_operand_a <= nxt.a;
                    s_operand_b <= nxt.b;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_result_value, '0);
                end else begin
                    alu_res_t want;
                    want = expected_results.pop_front();
                    if (m_result_value !== want.value)
                        report_mismatch("result_value", m_result_value, want.value);
                    if (m_compare_true !== want.cmp)
                        report_mismatch("compare_true", 32'(m_compare_true), 32'(want.cmp));
                    if (m_status !== want.st)
                        report_mismatch("status", 32'(m_status), 32'(want.st));
                end
            end
            // stall the receiver in random stretches
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                recv_gap = pick_gap();
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog and end of run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done);
        @(posedge aclk);
        while (pending_ops.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
